// ----- design/tsq_pkg.sv -----
// shared types, constants and codes of the two-stack queue
package tsq_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ID_W        = 32;
  localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
  localparam int COUNT_W     = 6;
  localparam int SUM_W       = (FILL_W + 1 > COUNT_W) ? FILL_W + 1 : COUNT_W;

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [FILL_W-1:0] fill_t;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    STAT_ENQUEUED = 3'd0,
    STAT_POPPED   = 3'd1,
    STAT_REFILLED = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REFILL,
    S_POP,
    S_REPORT
  } tsq_state_t;

  // shift command for a chain of cells: push moves every word one cell deeper
  typedef struct packed {
    logic push;
    logic pop;
  } stack_cmd_t;

endpackage

// ----- design/tsq_cell.sv -----
// one storage cell of a stack chain
module tsq_cell (
  input  logic             clk,
  input  tsq_pkg::stack_cmd_t cmd,
  input  tsq_pkg::id_t     from_above,
  input  tsq_pkg::id_t     from_below,
  output tsq_pkg::id_t     data
);
  import tsq_pkg::*;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      data <= from_above;
    end else if (cmd.pop) begin
      data <= from_below;
    end
  end

endmodule

// ----- design/tsq_stack.sv -----
// stack built as a chain of cells, top word in cell zero
module tsq_stack (
  input  logic                clk,
  input  logic                rst,
  input  tsq_pkg::stack_cmd_t cmd,
  input  tsq_pkg::id_t        push_data,
  output tsq_pkg::id_t        top_data,
  output tsq_pkg::id_t        bottom_data,
  output tsq_pkg::fill_t      fill
);
  import tsq_pkg::*;

  id_t   cell_data [STACK_DEPTH];
  id_t   bottom;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    id_t above;
    id_t below;
    if (i == 0) begin : g_first
      assign above = push_data;
    end else begin : g_inner
      assign above = cell_data[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_mid
      assign below = cell_data[i+1];
    end
    tsq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .from_above (above),
      .from_below (below),
      .data       (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.push) begin
      fill <= fill + FILL_W'(1);
    end else if (cmd.pop) begin
      fill <= fill - FILL_W'(1);
    end
  end

  // deepest word only changes when the first word goes onto an empty stack
  always_ff @(posedge clk) begin
    if (cmd.push && fill == '0) begin
      bottom <= push_data;
    end
  end

  assign top_data    = cell_data[0];
  assign bottom_data = bottom;

  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop))
    else $error("stack pushed and popped in one cycle");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> fill != FILL_W'(STACK_DEPTH))
    else $error("push onto full stack");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> fill != '0 ##1 fill == $past(fill) - FILL_W'(1))
    else $error("pop from empty stack or bad fill update");

endmodule

// ----- design/two_stack_queue_unit.sv -----
// two-stack queue top level: control sequencer, both stack chains, result register
// order: enqueue, direct pop, empty dequeue and full enqueue go from the accept step
//   through the report step into the result word; a refill pop first moves every entry in the refill step, then pops
// flow: a new word is accepted only in the idle step, after the report step of the last
//   one; a refill moves one entry per cycle through the cell chains
// reset: rst clears both fill counts and the output valid; stack cells are left
//   undefined until written, no clearing pass is needed
module two_stack_queue_unit (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // [31:0] item_id
  input  logic [0:0]   s_tuser,   // [0] opcode
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // [31:0] removed_id, [63:32] front_id, [95:64] back_id,
                                  // [96] not_empty, [102:97] item_count, [103] zero
  output logic [2:0]   m_tuser    // [2:0] status
);
  import tsq_pkg::*;

  tsq_state_t state, state_next;

  stack_cmd_t in_cmd, out_cmd;
  id_t        in_top, in_bottom, out_top, out_bottom;
  fill_t      in_fill, out_fill;

  // status and removed word of the word in flight
  status_t    status_r, status_next;
  id_t        removed_r, removed_next;
  logic       load_out;

  // result register
  status_t            res_status;
  id_t                res_removed, res_front, res_back;
  logic               res_not_empty;
  logic [COUNT_W-1:0] res_count;

  // report view of the queue, built from the settled stacks
  logic [SUM_W-1:0] total;
  id_t              front_now, back_now;

  // input stack takes new words, output stack is fed from the input top
  tsq_stack u_in_stack (
    .clk         (clk),
    .rst         (rst),
    .cmd         (in_cmd),
    .push_data   (s_tdata),
    .top_data    (in_top),
    .bottom_data (in_bottom),
    .fill        (in_fill)
  );

  tsq_stack u_out_stack (
    .clk         (clk),
    .rst         (rst),
    .cmd         (out_cmd),
    .push_data   (in_top),
    .top_data    (out_top),
    .bottom_data (out_bottom),
    .fill        (out_fill)
  );

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_cmd       = '0;
    out_cmd      = '0;
    status_next  = status_r;
    removed_next = removed_r;
    load_out     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          removed_next = '0;
          state_next   = S_REPORT;
          if (op_t'(s_tuser[0]) == OP_ENQ) begin
            if (in_fill == FILL_W'(STACK_DEPTH)) begin
              // full input stack: word dropped, nothing moves
              status_next = STAT_FULL;
            end else begin
              in_cmd.push = 1'b1;
              status_next = STAT_ENQUEUED;
            end
          end else if (out_fill != '0) begin
            out_cmd.pop  = 1'b1;
            removed_next = out_top;
            status_next  = STAT_POPPED;
          end else if (in_fill != '0) begin
            status_next = STAT_REFILLED;
            state_next  = S_REFILL;
          end else begin
            status_next = STAT_EMPTY;
          end
        end
      end
      S_REFILL: begin
        // one entry per cycle from the input top to the output top
        in_cmd.pop   = 1'b1;
        out_cmd.push = 1'b1;
        if (in_fill == FILL_W'(1)) begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        out_cmd.pop  = 1'b1;
        removed_next = out_top;
        state_next   = S_REPORT;
      end
      S_REPORT: begin
        // wait for room in the result register
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    status_r  <= status_next;
    removed_r <= removed_next;
  end

  // front reads the output stack first, back reads the input stack first
  assign total = SUM_W'(in_fill) + SUM_W'(out_fill);

  always_comb begin
    if (out_fill != '0) begin
      front_now = out_top;
    end else if (in_fill != '0) begin
      front_now = in_bottom;
    end else begin
      front_now = '0;
    end
    if (in_fill != '0) begin
      back_now = in_top;
    end else if (out_fill != '0) begin
      back_now = out_bottom;
    end else begin
      back_now = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_status    <= status_r;
      res_removed   <= removed_r;
      res_front     <= front_now;
      res_back      <= back_now;
      res_not_empty <= (total != '0);
      res_count     <= total[COUNT_W-1:0];
    end
  end

  assign m_tdata = {1'b0, res_count, res_not_empty, res_back, res_front, res_removed};
  assign m_tuser = res_status;

  a_refill_source: assert property (@(posedge clk) disable iff (rst)
    state == S_REFILL |-> in_fill != '0)
    else $error("refill step with empty input stack");

  a_refill_target: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && s_tvalid && status_next == STAT_REFILLED) |-> out_fill == '0)
    else $error("refill started with entries left in output stack");

  a_pop_after_refill: assert property (@(posedge clk) disable iff (rst)
    state == S_POP |-> out_fill != '0 && in_fill == '0)
    else $error("pop step without a completed refill");

  a_report_load: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_tvalid && m_tuser == $past(status_r))
    else $error("result word not loaded from report step");

endmodule
